FILE: src/bmprp_pkg.sv
// ----------------------------------------------------------------------------
// bmprp_pkg
// Shared types and constants for the bitmap row packer.
// ----------------------------------------------------------------------------
package bmprp_pkg;

   // pixel_format codes
   localparam logic [1:0] FMT_MONO = 2'd0;   // 1 bpp, luminance threshold
   localparam logic [1:0] FMT_GRAY = 2'd1;   // 8 bpp, low byte
   localparam logic [1:0] FMT_BGR  = 2'd2;   // 24 bpp
   localparam logic [1:0] FMT_BGRA = 2'd3;   // 32 bpp

   // configuration register indexes
   localparam logic [1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam int SIZE_W     = 14;
   localparam int FILE_ROW_W = 13;

   // luminance weights; (sum / 1000) > 127 is the same test as sum >= 128000
   localparam logic [17:0] LUM_R     = 18'd299;
   localparam logic [17:0] LUM_G     = 18'd587;
   localparam logic [17:0] LUM_B     = 18'd114;
   localparam logic [17:0] LUM_LIMIT = 18'd128000;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // one classified pixel: its data bytes, then zero padding
   typedef struct packed {
      logic [3:0][7:0]          bytes;     // B,G,R,A order; byte 0 holds mono byte
      logic [2:0]               ndata;     // data bytes to send, 1..4
      logic [1:0]               npad;      // padding bytes after them
      logic [FILE_ROW_W-1:0]    file_row;
      logic                     eor;
   } job_type;

endpackage

FILE: src/bmprp_front.sv
// ----------------------------------------------------------------------------
// bmprp_front
// Holds configuration and row state, classifies each pixel into a job.
// ----------------------------------------------------------------------------
module bmprp_front
   import bmprp_pkg::*;
#(
   parameter int MAX_WIDTH  = 8192,
   parameter int MAX_HEIGHT = 8192
) (
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [SIZE_W-1:0] csr_data,
   // pixels in
   input  logic              req_push,
   output logic              req_full,
   input  logic [31:0]       req_pixel,
   // job queue
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job
);

   localparam int CXW = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int RYW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW  = $clog2(MAX_HEIGHT + 1);

   logic [1:0]        fmt_ff;
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   logic [CXW-1:0]    col_ff,  col_in;
   logic [RYW-1:0]    row_ff,  row_in;
   logic [7:0]        acc_ff,  acc_in;

   logic [WW-1:0]     w_eff;
   logic [HW-1:0]     h_eff;
   logic [WW-1:0]     col_plus;
   logic              eor;
   logic [HW-1:0]     row_ext;
   logic [HW-1:0]     row_plus;
   logic [HW-1:0]     frow_full;
   logic [17:0]       lum_sum;
   logic [7:0]        acc_set;
   logic [CXW+1:0]    col_ext;
   logic [1:0]        col_low1;
   logic [1:0]        byte_cnt1;
   logic              flush;
   logic [2:0]        ndata;
   logic [1:0]        pad;
   logic              accept;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff    <= FMT_BGR;
         width_ff  <= SIZE_W'(1);
         height_ff <= SIZE_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_FORMAT: fmt_ff    <= csr_data[1:0];
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, oversize acts as the maximum
   always_comb begin
      if (width_ff == '0)
         w_eff = WW'(1);
      else if (int'(width_ff) > MAX_WIDTH)
         w_eff = WW'(MAX_WIDTH);
      else
         w_eff = WW'(width_ff);
      if (height_ff == '0)
         h_eff = HW'(1);
      else if (int'(height_ff) > MAX_HEIGHT)
         h_eff = HW'(MAX_HEIGHT);
      else
         h_eff = HW'(height_ff);
   end

   // row position
   assign col_plus = WW'(col_ff) + WW'(1);
   assign eor      = (col_plus >= w_eff);
   assign row_ext  = HW'(row_ff);
   assign row_plus = row_ext + HW'(1);

   always_comb begin
      if (row_ext < h_eff)
         frow_full = h_eff - HW'(1) - row_ext;
      else
         frow_full = '0;
   end

   // 1 bpp bit
   assign lum_sum = 18'(req_pixel[23:16]) * LUM_R
                  + 18'(req_pixel[15:8])  * LUM_G
                  + 18'(req_pixel[7:0])   * LUM_B;
   assign acc_set = acc_ff | ((lum_sum >= LUM_LIMIT) ? (8'h80 >> col_ff[2:0]) : 8'h00);
   assign flush   = (col_ff[2:0] == 3'd7) || eor;

   // low bits of the row byte count so far, for padding
   assign col_ext   = {2'b00, col_ff};
   assign col_low1  = 2'(col_ff[1:0] + 2'd1);
   assign byte_cnt1 = 2'(col_ext[4:3] + 2'd1);

   // classify by format
   always_comb begin
      q_job.bytes = req_pixel;
      case (fmt_ff)
         FMT_MONO: begin
            q_job.bytes[0] = acc_set;
            ndata          = flush ? 3'd1 : 3'd0;
            pad            = 2'(2'd0 - byte_cnt1);
         end
         FMT_GRAY: begin
            ndata = 3'd1;
            pad   = 2'(2'd0 - col_low1);
         end
         FMT_BGR: begin
            ndata = 3'd3;
            pad   = col_low1;
         end
         default: begin
            ndata = 3'd4;
            pad   = 2'd0;
         end
      endcase
      q_job.ndata    = ndata;
      q_job.npad     = eor ? pad : 2'd0;
      q_job.file_row = FILE_ROW_W'(frow_full);
      q_job.eor      = eor;
   end

   // handshake
   assign req_full = q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = accept && (ndata != 3'd0);

   // next row state
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      acc_in = acc_ff;
      if (accept) begin
         if (eor) begin
            col_in = '0;
            row_in = (row_plus >= h_eff) ? '0 : RYW'(row_plus);
            acc_in = 8'h00;
         end else begin
            col_in = CXW'(col_plus);
            if (fmt_ff == FMT_MONO)
               acc_in = flush ? 8'h00 : acc_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         acc_ff <= 8'h00;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         acc_ff <= acc_in;
      end
   end

endmodule

FILE: src/bmprp_queue.sv
// ----------------------------------------------------------------------------
// bmprp_queue
// Short queue of classified pixel jobs between front and back.
// ----------------------------------------------------------------------------
module bmprp_queue
   import bmprp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_job;
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         if (pop)
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         if (push && !pop)
            count_ff <= count_ff + (QUEUE_AW+1)'(1);
         else if (pop && !push)
            count_ff <= count_ff - (QUEUE_AW+1)'(1);
      end
   end

endmodule

FILE: src/bmprp_back.sv
// ----------------------------------------------------------------------------
// bmprp_back
// Walks each job one byte per cycle into the result register, while that register is empty or being popped.
// ----------------------------------------------------------------------------
module bmprp_back
   import bmprp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // job queue
   input  logic                  head_valid,
   input  job_type               head_job,
   output logic                  q_pop,
   // results out
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_byte_value,
   output logic [FILE_ROW_W-1:0] rsp_file_row,
   output logic                  rsp_end_of_row,
   output logic                  rsp_last
);

   logic [2:0]            idx_ff;
   logic                  out_valid_ff;
   logic [7:0]            byte_ff;
   logic [FILE_ROW_W-1:0] frow_ff;
   logic                  eor_ff;
   logic                  last_ff;

   logic [2:0]            total;
   logic                  is_final;
   logic                  advance;
   logic [7:0]            next_byte;

   // byte selection within the current job
   assign total     = head_job.ndata + 3'(head_job.npad);
   assign is_final  = (idx_ff == total - 3'd1);
   assign advance   = head_valid && (!out_valid_ff || rsp_pop);
   assign q_pop     = advance && is_final;
   assign next_byte = (idx_ff < head_job.ndata) ? head_job.bytes[idx_ff[1:0]] : 8'h00;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            idx_ff       <= is_final ? 3'd0 : idx_ff + 3'd1;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= next_byte;
         frow_ff <= head_job.file_row;
         eor_ff  <= head_job.eor && is_final;
         last_ff <= is_final;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_file_row   = frow_ff;
   assign rsp_end_of_row = eor_ff;
   assign rsp_last       = last_ff;

endmodule

FILE: src/bmp_row_packer.sv
// ----------------------------------------------------------------------------
// bmp_row_packer
// Packs A,R,G,B pixels into the bottom-up byte stream of a bitmap pixel array.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_push, req_full, req_pixel                 | in
//  rsp     | rsp_pop, rsp_empty, rsp_byte_value,           | out
//          | rsp_file_row, rsp_end_of_row, rsp_last        |
//  csr     | csr_valid, csr_ready, csr_index, csr_data     | in
//
//  Results leave one byte per cycle from the back end while rsp_pop takes
//  them; a pixel causes 0 or 1 bytes at 1 bpp, 1 at 8 bpp, 3 at 24 bpp,
//  4 at 32 bpp, plus up to 3 padding bytes at a row end. A pixel's first
//  byte passes through a job queue entry and then the result register
//  before it is on the result port.
//  Synchronous active-high reset clears counters and queue; the configuration
//  returns to 24 bpp, width 1, height 1. A four-entry job queue lets the
//  input keep taking pixels while results are stalled.
// ----------------------------------------------------------------------------
module bmp_row_packer
   import bmprp_pkg::*;
#(
   parameter int MAX_WIDTH  = 8192,
   parameter int MAX_HEIGHT = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [SIZE_W-1:0]     csr_data,
   // pixels in
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [31:0]           req_pixel,
   // bytes out
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_byte_value,
   output logic [FILE_ROW_W-1:0] rsp_file_row,
   output logic                  rsp_end_of_row,
   output logic                  rsp_last
);

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   job_type q_job_in;
   job_type q_job_out;

   // front: configuration, counters, pixel classification
   bmprp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job_in)
   );

   // job queue
   bmprp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job_in),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_job_out)
   );

   // back: byte sequencer and result register
   bmprp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_valid),
      .head_job       (q_job_out),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_byte_value (rsp_byte_value),
      .rsp_file_row   (rsp_file_row),
      .rsp_end_of_row (rsp_end_of_row),
      .rsp_last       (rsp_last)
   );

endmodule
